// ===== design/fpe_pkg.sv =====
// shared types, constants and plane component selection for the frustum plane extractor
`timescale 1ns / 1ps
`default_nettype none
package fpe_pkg;

    localparam int FracBits  = 16;
    localparam int NumPlanes = 6;
    localparam int NumRows   = 4;

    localparam logic [2:0] PlaneLeft   = 3'd0;
    localparam logic [2:0] PlaneRight  = 3'd1;
    localparam logic [2:0] PlaneTop    = 3'd2;
    localparam logic [2:0] PlaneBottom = 3'd3;
    localparam logic [2:0] PlaneNear   = 3'd4;
    localparam logic [2:0] PlaneFar    = 3'd5;

    localparam logic [1:0] RowOffset = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    function automatic logic signed [33:0] plane_comp(
        input logic [2:0]         p,
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic signed [31:0] c,
        input logic signed [31:0] d
    );
        logic signed [33:0] ea, eb, ec, ed, res;
        ea = {{2{a[31]}}, a};
        eb = {{2{b[31]}}, b};
        ec = {{2{c[31]}}, c};
        ed = {{2{d[31]}}, d};
        case (p)
            PlaneLeft:   res = ed + ea;
            PlaneRight:  res = ed - ea;
            PlaneTop:    res = ed - eb;
            PlaneBottom: res = ed + eb;
            PlaneNear:   res = ec;
            default:     res = ed - ec;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/fpe_div.sv =====
// restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor
`timescale 1ns / 1ps
`default_nettype none
module fpe_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo,
    output logic [31:0]      o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_num[63]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_quo <= {r_quo[62:0], w_ge};
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== design/frustum_plane_extractor.sv =====
// top level: row storage, per-plane normalisation sequencer and result register
//
// a 4x4 matrix is sent one row per request: i_start with i_row_index and the
// four row elements (signed q16.16) is taken at a clock edge where o_busy is
// low. rows 0 to 2 are only stored; o_busy stays low. a request carrying
// row 3 stores it and then runs the six planes in turn (left, right, top,
// bottom, near, far) with o_busy high. each plane is brought to a fixed
// magnitude range one bit a cycle, its squared normal length is summed over
// the three components, an integer square root is taken, and one shared
// restoring divider is used five times (three normal components, offset
// quotient, offset fraction). a plane whose normal is zero goes straight
// from load to emit.
// each plane result is held on the o_ ports for one cycle with o_valid high;
// o_last_plane marks the far plane. the receiver cannot stall, so results
// leave at once. reset clears the sequencer and the strobe; stored rows are
// undefined until written, so rows 0 to 2 must be sent before row 3.
`timescale 1ns / 1ps
`default_nettype none
module frustum_plane_extractor (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_row_index,
    input  wire logic signed [31:0] i_elem_a,
    input  wire logic signed [31:0] i_elem_b,
    input  wire logic signed [31:0] i_elem_c,
    input  wire logic signed [31:0] i_elem_d,
    output logic                    o_valid,
    output logic [2:0]              o_plane_index,
    output logic signed [31:0]      o_normal_x,
    output logic signed [31:0]      o_normal_y,
    output logic signed [31:0]      o_normal_z,
    output logic signed [31:0]      o_distance,
    output logic                    o_degenerate,
    output logic                    o_last_plane
);

    localparam int F = fpe_pkg::FracBits;

    fpe_pkg::t_state r_state, n_state;

    logic signed [31:0] r_row_a [fpe_pkg::NumRows];
    logic signed [31:0] r_row_b [fpe_pkg::NumRows];
    logic signed [31:0] r_row_c [fpe_pkg::NumRows];
    logic signed [31:0] r_row_d [fpe_pkg::NumRows];

    logic [2:0]  r_plane;
    logic        r_degen;
    logic [33:0] r_mg [3];
    logic [63:0] r_mg3;
    logic [3:0]  r_neg;
    logic [63:0] r_acc;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic [2:0]  r_k;
    logic [31:0] r_nq [3];
    logic [33:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_frac;

    logic               r_valid;
    logic [2:0]         r_o_plane;
    logic signed [31:0] r_o_nx, r_o_ny, r_o_nz, r_o_dist;
    logic               r_o_degen, r_o_last;

    logic               w_accept;
    logic signed [33:0] w_comp [fpe_pkg::NumRows];
    logic [33:0]        w_mag [fpe_pkg::NumRows];
    logic [33:0]        w_m01, w_m;
    logic [33:0]        w_sq_op;
    logic [63:0]        w_sq_prod;
    logic [63:0]        w_trial;
    logic [31:0]        w_len;
    logic [63:0]        w_div_num;
    logic               w_div_start;
    logic               w_emit;
    logic               w_div_done;
    logic [63:0]        w_div_quo;
    logic [31:0]        w_div_rem;
    logic [33:0]        w_tot;
    logic [33:0]        w_tot_sat;
    logic [33:0]        w_tot_neg;

    assign w_accept = i_start && !o_busy;
    assign o_busy   = (r_state != fpe_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row_a[i_row_index] <= i_elem_a;
            r_row_b[i_row_index] <= i_elem_b;
            r_row_c[i_row_index] <= i_elem_c;
            r_row_d[i_row_index] <= i_elem_d;
        end
    end

    always_comb begin
        for (int k = 0; k < fpe_pkg::NumRows; k++) begin
            w_comp[k] = fpe_pkg::plane_comp(r_plane, r_row_a[k], r_row_b[k],
                                            r_row_c[k], r_row_d[k]);
            w_mag[k]  = w_comp[k][33] ? 34'(-w_comp[k]) : 34'(w_comp[k]);
        end
        w_m01 = (r_mg[1] > r_mg[0]) ? r_mg[1] : r_mg[0];
        w_m   = (r_mg[2] > w_m01) ? r_mg[2] : w_m01;
    end

    always_comb begin
        case (r_k)
            3'd0:    w_sq_op = r_mg[0];
            3'd1:    w_sq_op = r_mg[1];
            default: w_sq_op = r_mg[2];
        endcase
        w_sq_prod = 64'(w_sq_op[30:0]) * 64'(w_sq_op[30:0]);
        w_trial   = r_res + r_bit;
        w_len     = r_res[31:0];
        case (r_k)
            3'd3:    w_div_num = r_mg3;
            3'd4:    w_div_num = (64'(r_rem) << F) + 64'(w_len >> 1);
            default: w_div_num = (64'(w_sq_op[30:0]) << F) + 64'(w_len >> 1);
        endcase
    end

    fpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_len),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpe_pkg::S_IDLE: begin
                if (w_accept && i_row_index == fpe_pkg::RowOffset) begin
                    n_state = fpe_pkg::S_LOAD;
                end
            end
            fpe_pkg::S_LOAD: begin
                if (w_mag[0] == '0 && w_mag[1] == '0 && w_mag[2] == '0) begin
                    n_state = fpe_pkg::S_EMIT;
                end else begin
                    n_state = fpe_pkg::S_NORM;
                end
            end
            fpe_pkg::S_NORM: begin
                if (w_m[33:30] != '0 && w_m[33:31] == '0) begin
                    n_state = fpe_pkg::S_SQ;
                end
            end
            fpe_pkg::S_SQ: begin
                if (r_k == 3'd2) begin
                    n_state = fpe_pkg::S_SQRT;
                end
            end
            fpe_pkg::S_SQRT: begin
                if (r_cnt == 5'd31) begin
                    n_state = fpe_pkg::S_DIV_START;
                end
            end
            fpe_pkg::S_DIV_START: begin
                n_state = fpe_pkg::S_DIV_WAIT;
            end
            fpe_pkg::S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_k == 3'd4) ? fpe_pkg::S_EMIT : fpe_pkg::S_DIV_START;
                end
            end
            fpe_pkg::S_EMIT: begin
                n_state = (r_plane == fpe_pkg::PlaneFar) ? fpe_pkg::S_IDLE
                                                         : fpe_pkg::S_LOAD;
            end
            default: n_state = fpe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = (r_state == fpe_pkg::S_DIV_START);
        w_emit      = (r_state == fpe_pkg::S_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpe_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fpe_pkg::S_IDLE: begin
                r_plane <= fpe_pkg::PlaneLeft;
            end
            fpe_pkg::S_LOAD: begin
                r_degen <= (w_mag[0] == '0 && w_mag[1] == '0 && w_mag[2] == '0);
                for (int k = 0; k < 3; k++) begin
                    r_mg[k] <= w_mag[k];
                end
                r_mg3 <= 64'(w_mag[3]);
                for (int k = 0; k < fpe_pkg::NumRows; k++) begin
                    r_neg[k] <= w_comp[k][33];
                end
                r_k   <= '0;
                r_acc <= '0;
            end
            fpe_pkg::S_NORM: begin
                if (w_m[33:30] == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mg[k] <= {r_mg[k][32:0], 1'b0};
                    end
                    r_mg3 <= {r_mg3[62:0], 1'b0};
                end else if (w_m[33:31] != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mg[k] <= {1'b0, r_mg[k][33:1]};
                    end
                    r_mg3 <= {1'b0, r_mg3[63:1]};
                end
            end
            fpe_pkg::S_SQ: begin
                r_acc <= r_acc + w_sq_prod;
                r_k   <= r_k + 3'd1;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            fpe_pkg::S_SQRT: begin
                if (r_acc >= w_trial) begin
                    r_acc <= r_acc - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                r_k   <= '0;
            end
            fpe_pkg::S_DIV_START: begin
            end
            fpe_pkg::S_DIV_WAIT: begin
                if (w_div_done) begin
                    case (r_k)
                        3'd0: r_nq[0] <= w_div_quo[31:0];
                        3'd1: r_nq[1] <= w_div_quo[31:0];
                        3'd2: r_nq[2] <= w_div_quo[31:0];
                        3'd3: begin
                            r_q   <= w_div_quo[33:0];
                            r_rem <= w_div_rem;
                        end
                        default: r_frac <= w_div_quo[31:0];
                    endcase
                    r_k <= r_k + 3'd1;
                end
            end
            fpe_pkg::S_EMIT: begin
                r_plane <= r_plane + 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if ((r_q >> (32 - F)) != '0) begin
            w_tot = 34'd1 << 32;
        end else begin
            w_tot = (r_q << F) + 34'(r_frac);
        end
        if (r_neg[3]) begin
            w_tot_sat = (w_tot > (34'd1 << 31)) ? (34'd1 << 31) : w_tot;
        end else begin
            w_tot_sat = (w_tot > 34'h7FFF_FFFF) ? 34'h7FFF_FFFF : w_tot;
        end
        w_tot_neg = 34'(-w_tot_sat);
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_plane <= r_plane;
            r_o_last  <= (r_plane == fpe_pkg::PlaneFar);
            r_o_degen <= r_degen;
            if (r_degen) begin
                r_o_nx   <= '0;
                r_o_ny   <= '0;
                r_o_nz   <= '0;
                r_o_dist <= '0;
            end else begin
                r_o_nx   <= r_neg[0] ? 32'(-r_nq[0]) : r_nq[0];
                r_o_ny   <= r_neg[1] ? 32'(-r_nq[1]) : r_nq[1];
                r_o_nz   <= r_neg[2] ? 32'(-r_nq[2]) : r_nq[2];
                r_o_dist <= r_neg[3] ? w_tot_neg[31:0] : w_tot_sat[31:0];
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_plane_index = r_o_plane;
    assign o_normal_x    = r_o_nx;
    assign o_normal_y    = r_o_ny;
    assign o_normal_z    = r_o_nz;
    assign o_distance    = r_o_dist;
    assign o_degenerate  = r_o_degen;
    assign o_last_plane  = r_o_last;

endmodule
`default_nettype wire
